FILE: sv/assert_macros.svh
// Assertion macros for the unit direction vector checker.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check while out of reset
`define UVD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("unit_direction_vector check failed");
// check at every edge, reset included
`define UVD_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("unit_direction_vector check failed");
`endif

FILE: sv/uvd_pkg.sv
// Shared widths and pipeline item types for unit_direction_vector.
// No dependencies.
`default_nettype none
package uvd_pkg;
	localparam int COORD_W     = 32;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int MAG_W       = COORD_W;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int SUM_W       = SQ_W + 2;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int SQRT_REM_W  = ROOT_W + 1;
	localparam int SQRT_STEPS  = SUM_W / 2;
	localparam int DIR_FRAC    = 30;
	localparam int Q_W         = DIR_FRAC + 1;
	localparam int DIR_W       = 32;
	localparam int DREM_W      = ROOT_W + 1;
	localparam int DIV_STEPS   = Q_W;
	localparam int LANES       = 3;

	typedef struct packed {
		logic [SUM_W-1:0]                rad;
		logic [SQRT_REM_W-1:0]           rem;
		logic [ROOT_W-1:0]               root;
		logic [LANES-1:0][MAG_W-1:0]     mag;
		logic [LANES-1:0]                neg;
	} sq_item_t;

	typedef struct packed {
		logic [LANES-1:0][DREM_W-1:0]    r;
		logic [LANES-1:0][Q_W-1:0]       q;
		logic [ROOT_W-1:0]               d;
		logic [LANES-1:0]                neg;
	} div_item_t;
endpackage
`default_nettype wire

FILE: sv/unit_direction_vector.sv
// Pipeline: 4 front stages, 33 square root steps, 31 divide steps, output register.
// Throughput one request per cycle; the whole pipe holds while a result is stalled.
// Each square root step and each divide step resolves one bit.
// Reset clears the valid bits only; no state survives between requests.
// Uses uvd_pkg, uvd_front, uvd_sqrt_step, uvd_div_step.
`default_nettype none
module unit_direction_vector (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   start_x,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   start_y,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   start_z,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   end_x,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   end_y,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   end_z,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [uvd_pkg::DIR_W-1:0]          dir_x,
	output logic signed [uvd_pkg::DIR_W-1:0]          dir_y,
	output logic signed [uvd_pkg::DIR_W-1:0]          dir_z,
	output logic [uvd_pkg::ROOT_W-1:0]                distance,
	output logic                                       zero_length
);
	logic                 en;
	logic                 sq_v   [0:uvd_pkg::SQRT_STEPS];
	uvd_pkg::sq_item_t    sq_it  [0:uvd_pkg::SQRT_STEPS];
	logic                 dv_v   [0:uvd_pkg::DIV_STEPS];
	uvd_pkg::div_item_t   dv_it  [0:uvd_pkg::DIV_STEPS];
	uvd_pkg::div_item_t   last;
	logic                 zero_c;
	logic [uvd_pkg::LANES-1:0][uvd_pkg::DIR_W-1:0] dir_c;
	logic                                       out_v_q;
	logic [uvd_pkg::LANES-1:0][uvd_pkg::DIR_W-1:0] dir_q;
	logic [uvd_pkg::ROOT_W-1:0]                 dist_q;
	logic                                       zero_q;

	assign en       = !(out_v_q && out_stall);
	assign in_stall = !en;

	uvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (in_valid),
		.start_x  (start_x),
		.start_y  (start_y),
		.start_z  (start_z),
		.end_x    (end_x),
		.end_y    (end_y),
		.end_z    (end_z),
		.v_out    (sq_v[0]),
		.item_out (sq_it[0])
	);

	for (genvar k = 0; k < uvd_pkg::SQRT_STEPS; k++) begin : g_sqrt
		uvd_sqrt_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (sq_v[k]),
			.item_in  (sq_it[k]),
			.v_out    (sq_v[k+1]),
			.item_out (sq_it[k+1])
		);
	end

	always_comb begin
		dv_v[0]     = sq_v[uvd_pkg::SQRT_STEPS];
		dv_it[0].d  = sq_it[uvd_pkg::SQRT_STEPS].root;
		dv_it[0].neg = sq_it[uvd_pkg::SQRT_STEPS].neg;
		for (int i = 0; i < uvd_pkg::LANES; i++) begin
			dv_it[0].r[i] = {{(uvd_pkg::DREM_W-uvd_pkg::MAG_W){1'b0}},
				sq_it[uvd_pkg::SQRT_STEPS].mag[i]};
			dv_it[0].q[i] = '0;
		end
	end

	for (genvar k = 0; k < uvd_pkg::DIV_STEPS; k++) begin : g_div
		uvd_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (dv_v[k]),
			.item_in  (dv_it[k]),
			.v_out    (dv_v[k+1]),
			.item_out (dv_it[k+1])
		);
	end

	always_comb begin
		last   = dv_it[uvd_pkg::DIV_STEPS];
		zero_c = last.d == '0;
		for (int i = 0; i < uvd_pkg::LANES; i++) begin
			if (zero_c) begin
				dir_c[i] = '0;
			end else if (last.neg[i]) begin
				dir_c[i] = -{{(uvd_pkg::DIR_W-uvd_pkg::Q_W){1'b0}}, last.q[i]};
			end else begin
				dir_c[i] = {{(uvd_pkg::DIR_W-uvd_pkg::Q_W){1'b0}}, last.q[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v[uvd_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_q  <= dir_c;
			dist_q <= last.d;
			zero_q <= zero_c;
		end
	end

	assign out_valid   = out_v_q;
	assign dir_x       = dir_q[0];
	assign dir_y       = dir_q[1];
	assign dir_z       = dir_q[2];
	assign distance    = dist_q;
	assign zero_length = zero_q;
endmodule
`default_nettype wire

FILE: sv/uvd_front.sv
// Front end: difference, magnitude, squares and sum of squares, four stages.
// Uses uvd_pkg.
`default_nettype none
module uvd_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  v_in,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   start_x,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   start_y,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   start_z,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   end_x,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   end_y,
	input  wire logic signed [uvd_pkg::COORD_W-1:0]   end_z,
	output logic                                       v_out,
	output uvd_pkg::sq_item_t                          item_out
);
	logic [uvd_pkg::LANES-1:0][uvd_pkg::DIFF_W-1:0] diff_s1;
	logic [uvd_pkg::LANES-1:0][uvd_pkg::MAG_W-1:0]  mag_s2, mag_s3, mag_s4;
	logic [uvd_pkg::LANES-1:0]                       neg_s2, neg_s3, neg_s4;
	logic [uvd_pkg::LANES-1:0][uvd_pkg::SQ_W-1:0]   sq_s3;
	logic [uvd_pkg::SUM_W-1:0]                       sum_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [uvd_pkg::LANES-1:0][uvd_pkg::DIFF_W-1:0] diff_c, neg_c;

	always_comb begin
		diff_c[0] = {end_x[uvd_pkg::COORD_W-1], end_x} - {start_x[uvd_pkg::COORD_W-1], start_x};
		diff_c[1] = {end_y[uvd_pkg::COORD_W-1], end_y} - {start_y[uvd_pkg::COORD_W-1], start_y};
		diff_c[2] = {end_z[uvd_pkg::COORD_W-1], end_z} - {start_z[uvd_pkg::COORD_W-1], start_z};
		for (int i = 0; i < uvd_pkg::LANES; i++) begin
			neg_c[i] = -diff_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff_c;
			for (int i = 0; i < uvd_pkg::LANES; i++) begin
				neg_s2[i] <= diff_s1[i][uvd_pkg::DIFF_W-1];
				mag_s2[i] <= diff_s1[i][uvd_pkg::DIFF_W-1] ?
					neg_c[i][uvd_pkg::MAG_W-1:0] : diff_s1[i][uvd_pkg::MAG_W-1:0];
				sq_s3[i] <= mag_s2[i] * mag_s2[i];
			end
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			sum_s4 <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	always_comb begin
		v_out         = v_s4;
		item_out.rad  = sum_s4;
		item_out.rem  = '0;
		item_out.root = '0;
		item_out.mag  = mag_s4;
		item_out.neg  = neg_s4;
	end
endmodule
`default_nettype wire

FILE: sv/uvd_sqrt_step.sv
// One registered step of the digit-by-digit square root, one root bit.
// Uses uvd_pkg.
`default_nettype none
module uvd_sqrt_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire uvd_pkg::sq_item_t item_in,
	output logic                   v_out,
	output uvd_pkg::sq_item_t      item_out
);
	logic                              v_s1;
	uvd_pkg::sq_item_t                 item_s1;
	logic [uvd_pkg::SQRT_REM_W+1:0]    cat;
	logic [uvd_pkg::ROOT_W+1:0]        trial;
	logic                              ge;
	logic [uvd_pkg::SQRT_REM_W+1:0]    diff;

	always_comb begin
		cat   = {item_in.rem, item_in.rad[uvd_pkg::SUM_W-1 -: 2]};
		trial = {item_in.root, 2'b01};
		ge    = cat >= {1'b0, trial};
		diff  = cat - {1'b0, trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.rad  <= item_in.rad << 2;
			item_s1.rem  <= ge ? diff[uvd_pkg::SQRT_REM_W-1:0] : cat[uvd_pkg::SQRT_REM_W-1:0];
			item_s1.root <= {item_in.root[uvd_pkg::ROOT_W-2:0], ge};
			item_s1.mag  <= item_in.mag;
			item_s1.neg  <= item_in.neg;
		end
	end

	assign v_out    = v_s1;
	assign item_out = item_s1;
endmodule
`default_nettype wire

FILE: sv/uvd_div_step.sv
// One registered restoring division step for three lanes, one quotient bit.
// Uses uvd_pkg.
`default_nettype none
module uvd_div_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               v_in,
	input  wire uvd_pkg::div_item_t item_in,
	output logic                    v_out,
	output uvd_pkg::div_item_t      item_out
);
	logic                                              v_s1;
	uvd_pkg::div_item_t                                item_s1;
	logic [uvd_pkg::LANES-1:0]                         ge;
	logic [uvd_pkg::LANES-1:0][uvd_pkg::DREM_W-1:0]    rn;

	always_comb begin
		for (int i = 0; i < uvd_pkg::LANES; i++) begin
			ge[i] = item_in.r[i] >= {1'b0, item_in.d};
			rn[i] = ge[i] ? item_in.r[i] - {1'b0, item_in.d} : item_in.r[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < uvd_pkg::LANES; i++) begin
				item_s1.r[i] <= rn[i] << 1;
				item_s1.q[i] <= {item_in.q[i][uvd_pkg::Q_W-2:0], ge[i]};
			end
			item_s1.d   <= item_in.d;
			item_s1.neg <= item_in.neg;
		end
	end

	assign v_out    = v_s1;
	assign item_out = item_s1;
endmodule
`default_nettype wire

FILE: sv/uvd_checker.sv
// Port-level checks for unit_direction_vector, bound to the top level.
// Uses assert_macros.svh and uvd_pkg.
`default_nettype none
`include "assert_macros.svh"
module uvd_port_checks (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_stall,
	input  wire logic                                  out_valid,
	input  wire logic                                  out_stall,
	input  wire logic signed [uvd_pkg::DIR_W-1:0]     dir_x,
	input  wire logic signed [uvd_pkg::DIR_W-1:0]     dir_y,
	input  wire logic signed [uvd_pkg::DIR_W-1:0]     dir_z,
	input  wire logic [uvd_pkg::ROOT_W-1:0]           distance,
	input  wire logic                                  zero_length
);
	localparam logic signed [uvd_pkg::DIR_W-1:0] ONE = 1 <<< uvd_pkg::DIR_FRAC;

	logic dirs_zero;
	logic dirs_in_range;

	assign dirs_zero     = dir_x == 0 && dir_y == 0 && dir_z == 0;
	assign dirs_in_range = dir_x <= ONE && dir_x >= -ONE && dir_y <= ONE && dir_y >= -ONE
		&& dir_z <= ONE && dir_z >= -ONE;

	`UVD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(distance))
	`UVD_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)
	`UVD_ASSERT(a_zero_result, out_valid && zero_length |-> dirs_zero && distance == 0)
	`UVD_ASSERT(a_nonzero_len, out_valid && !zero_length |-> distance != 0)
	`UVD_ASSERT_ALWAYS(a_dir_range, !out_valid || dirs_in_range)
endmodule

bind unit_direction_vector uvd_port_checks u_uvd_port_checks (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.dir_x       (dir_x),
	.dir_y       (dir_y),
	.dir_z       (dir_z),
	.distance    (distance),
	.zero_length (zero_length)
);
`default_nettype wire
